// ----- rtl/iq_sample_packet_framer_defines.svh -----
// Assertion macros shared by the I/Q packet framer RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef IQ_SAMPLE_PACKET_FRAMER_DEFINES_SVH
`define IQ_SAMPLE_PACKET_FRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset masked.
`define IQF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iqf: implication check failed");
// Next-cycle implication, reset masked.
`define IQF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iqf: next-cycle check failed");
`else
`define IQF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define IQF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/iqf_pkg.sv -----
// Shared types, constants and functions of the I/Q sample packet framer.
// Depends on nothing; every other RTL file but the assertion macro header imports it.
package iqf_pkg;

   localparam int SAMPLE_W         = 16;
   localparam int CNT_W            = 11;
   localparam int BYTE_W           = 8;
   localparam int SEQ_W            = 16;
   localparam int PACKET_PAIRS_MAX = 1024;
   localparam int QUEUE_DEPTH      = 2;

   // Header sync characters
   localparam logic [BYTE_W-1:0] SYNC_0 = 8'h44;   // 'D'
   localparam logic [BYTE_W-1:0] SYNC_1 = 8'h54;   // 'T'

   // Offset conversion: round((x + 1) * 32767) for Q1.15 x
   localparam logic [SAMPLE_W-1:0] SIGN_FLIP    = 16'h8000;
   localparam logic [SAMPLE_W-1:0] OFFSET_SCALE = 16'd32767;
   localparam logic [SAMPLE_W-1:0] OFFSET_ROUND = 16'd16384;

   localparam logic [SEQ_W-1:0] SEQ_STEP = 16'd2;

   // Byte positions inside one job; a job without header starts at IDX_I_HI
   localparam int IDX_W = 4;
   localparam logic [IDX_W-1:0] IDX_SYNC_0 = 4'd0;
   localparam logic [IDX_W-1:0] IDX_SYNC_1 = 4'd1;
   localparam logic [IDX_W-1:0] IDX_SEQ_LO = 4'd2;
   localparam logic [IDX_W-1:0] IDX_SEQ_HI = 4'd3;
   localparam logic [IDX_W-1:0] IDX_CNT_LO = 4'd4;
   localparam logic [IDX_W-1:0] IDX_CNT_HI = 4'd5;
   localparam logic [IDX_W-1:0] IDX_I_HI   = 4'd6;
   localparam logic [IDX_W-1:0] IDX_I_LO   = 4'd7;
   localparam logic [IDX_W-1:0] IDX_Q_HI   = 4'd8;
   localparam logic [IDX_W-1:0] IDX_Q_LO   = 4'd9;

   // One classified item handed from front to back
   typedef struct packed {
      logic                has_header;
      logic [SEQ_W-1:0]    seq;
      logic [CNT_W-1:0]    cnt;
      logic [SAMPLE_W-1:0] iv;
      logic [SAMPLE_W-1:0] qv;
      logic                eop;
   } job_type;

   function automatic logic [SAMPLE_W-1:0] to_offset16(input logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] biased;
      logic [31:0]         prod;
      biased = raw ^ SIGN_FLIP;
      prod   = 32'(biased) * 32'(OFFSET_SCALE) + 32'(OFFSET_ROUND);
      return prod[30:15];
   endfunction

   // Step by two; on overflow restart at 1 from an even value, 0 from an odd one
   function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] seq);
      logic [SEQ_W:0] sum;
      sum = {1'b0, seq} + {1'b0, SEQ_STEP};
      if (sum[SEQ_W]) begin
         return {{(SEQ_W-1){1'b0}}, ~sum[0]};
      end
      return sum[SEQ_W-1:0];
   endfunction

endpackage

// ----- rtl/iqf_if.sv -----
// Valid/ready channel interfaces of the I/Q sample packet framer.
// Depends on iqf_pkg for field widths.
interface iqf_req_if import iqf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_i;
   logic signed [SAMPLE_W-1:0] sample_q;
   logic                       first_of_packet;
   logic [CNT_W-1:0]           packet_samples;

   modport source (output valid, sample_i, sample_q, first_of_packet, packet_samples,
                   input ready);
   modport sink   (input valid, sample_i, sample_q, first_of_packet, packet_samples,
                   output ready);
endinterface

interface iqf_rsp_if import iqf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_of_item;
   logic              end_of_packet;

   modport source (output valid, data_byte, last_of_item, end_of_packet, input ready);
   modport sink   (input valid, data_byte, last_of_item, end_of_packet, output ready);
endinterface

// ----- rtl/iq_sample_packet_framer.sv -----
// I/Q sample packet framer. Each accepted sample transaction on req_ch becomes
// byte transactions on rsp_ch, one byte per cycle at most: a sample pair gives
// four bytes (I high, I low, Q high, Q low, each round((x+1)*32767) as unsigned
// 16 bits), and a transaction marked first_of_packet gives a six-byte header
// before them ('D', 'T', sequence number low/high, sample count low/high), so
// ten bytes. Bytes are paced by the byte-wide output register of the back end,
// which takes the next job as it emits the last byte of the current one.
// A sample that arrives with no packet open is accepted and dropped.
// The front end accepts one transaction per cycle while the two-entry job
// queue has room, so input and output stall independently. Each job passes
// the queue, the back end's job register and the output register to rsp_ch.
// Count zero is sent as one, counts above PacketPairsMax saturate, and a new
// packet start abandons any open packet without an end_of_packet mark.
// Depends on iqf_pkg, iqf_if and the front, queue and back modules.
module iq_sample_packet_framer import iqf_pkg::*; #(
   parameter int PacketPairsMax = PACKET_PAIRS_MAX
) (
   input  logic      clock,
   input  logic      reset,
   iqf_req_if.sink   req_ch,
   iqf_rsp_if.source rsp_ch
);

   // Classified jobs from the front end into the queue
   logic    push_valid;
   logic    push_ready;
   job_type push_job;

   // Jobs from the queue into the byte serializer
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   // Accept, track sequence number and open packet, convert samples
   iqf_front #(
      .PacketPairsMax (PacketPairsMax)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   // Decouple acceptance from byte output
   iqf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   // Serialize header and sample bytes, one per cycle unless rsp_ch stalls
   iqf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp       (rsp_ch)
   );

endmodule

// ----- rtl/iqf_front.sv -----
// Front end: accepts sample transactions, tracks packet state, builds jobs.
// Depends on iqf_pkg and iqf_req_if.
module iqf_front import iqf_pkg::*; #(
   parameter int PacketPairsMax = PACKET_PAIRS_MAX
) (
   input  logic       clock,
   input  logic       reset,
   iqf_req_if.sink    req,
   output logic       push_valid,
   output job_type    push_job,
   input  logic       push_ready
);

   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [CNT_W-1:0] remaining_ff, remaining_in;
   logic [CNT_W-1:0] cnt_adj;
   logic [CNT_W-1:0] rem_now;
   logic             accept;
   logic             open;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   always_comb begin
      cnt_adj = req.packet_samples;
      if (req.packet_samples == '0) begin
         cnt_adj = CNT_W'(1);
      end else if (32'(req.packet_samples) > 32'(PacketPairsMax)) begin
         cnt_adj = CNT_W'(PacketPairsMax);
      end

      rem_now = req.first_of_packet ? cnt_adj : remaining_ff;
      open    = req.first_of_packet || (remaining_ff != '0);

      push_valid          = accept && open;
      push_job.has_header = req.first_of_packet;
      push_job.seq        = seq_ff;
      push_job.cnt        = cnt_adj;
      push_job.iv         = to_offset16(req.sample_i);
      push_job.qv         = to_offset16(req.sample_q);
      push_job.eop        = (rem_now == CNT_W'(1));

      seq_in       = seq_ff;
      remaining_in = remaining_ff;
      if (accept) begin
         if (req.first_of_packet) begin
            seq_in = seq_next(seq_ff);
         end
         if (open) begin
            remaining_in = rem_now - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         remaining_ff <= '0;
      end else begin
         seq_ff       <= seq_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

// ----- rtl/iqf_queue.sv -----
// Short job queue between front and back; lets each side stall alone.
// Depends on iqf_pkg.
module iqf_queue import iqf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    push_ready,
   output logic    pop_valid,
   output job_type pop_job,
   input  logic    pop_ready
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

   job_type         entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/iqf_back.sv -----
// Back end: serializes each job into bytes through an output register.
// Depends on iqf_pkg, iqf_rsp_if and the assertion macro header.
`include "iq_sample_packet_framer_defines.svh"
module iqf_back import iqf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   input  job_type    pop_job,
   output logic       pop_ready,
   iqf_rsp_if.source  rsp
);

   job_type          cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;
   logic             out_eop_ff, out_eop_in;
   logic             emit, at_end;

   assign emit      = busy_ff && (!out_valid_ff || rsp.ready);
   assign at_end    = (idx_ff == IDX_Q_LO);
   assign pop_ready = !busy_ff || (emit && at_end);

   assign rsp.valid         = out_valid_ff;
   assign rsp.data_byte     = out_byte_ff;
   assign rsp.last_of_item  = out_last_ff;
   assign rsp.end_of_packet = out_eop_ff;

   always_comb begin
      case (idx_ff)
         IDX_SYNC_0: out_byte_in = SYNC_0;
         IDX_SYNC_1: out_byte_in = SYNC_1;
         IDX_SEQ_LO: out_byte_in = cur_ff.seq[7:0];
         IDX_SEQ_HI: out_byte_in = cur_ff.seq[15:8];
         IDX_CNT_LO: out_byte_in = cur_ff.cnt[7:0];
         IDX_CNT_HI: out_byte_in = BYTE_W'(cur_ff.cnt[CNT_W-1:8]);
         IDX_I_HI:   out_byte_in = cur_ff.iv[15:8];
         IDX_I_LO:   out_byte_in = cur_ff.iv[7:0];
         IDX_Q_HI:   out_byte_in = cur_ff.qv[15:8];
         IDX_Q_LO:   out_byte_in = cur_ff.qv[7:0];
         default:    out_byte_in = '0;
      endcase
      out_last_in = at_end;
      out_eop_in  = at_end && cur_ff.eop;

      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end

      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (pop_valid && pop_ready) begin
         cur_in  = pop_job;
         idx_in  = pop_job.has_header ? IDX_SYNC_0 : IDX_I_HI;
         busy_in = 1'b1;
      end else if (emit && at_end) begin
         busy_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= IDX_SYNC_0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
         out_eop_ff  <= out_eop_in;
      end
   end

   `IQF_ASSERT_IMPLIES(a_eop_is_last, clock, reset, rsp.valid && rsp.end_of_packet, rsp.last_of_item)
   `IQF_ASSERT_IMPLIES(a_header_pos, clock, reset, busy_ff && (idx_ff < IDX_I_HI), cur_ff.has_header)
   `IQF_ASSERT_IMPLIES(a_idx_range, clock, reset, busy_ff, idx_ff <= IDX_Q_LO)
   `IQF_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp.valid)

endmodule

// ----- verif/iq_framer_byte_checker.sv -----
`timescale 1ns / 1ps
// Watches both channels of the I/Q packet framer, predicts every byte and compares.
// Depends on iqf_pkg and the channel interfaces in iqf_if.
module iq_framer_byte_checker import iqf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   iqf_req_if        req_mon,
   iqf_rsp_if        rsp_mon,
   output int        mismatch_count,
   output int        pending_bytes,
   output int        bytes_checked,
   output int        packets_opened,
   output int        samples_dropped,
   output int        packets_abandoned
);

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last_of_item;
      logic              end_of_packet;
   } framed_byte_type;

   framed_byte_type   expected_bytes[$];
   logic [SEQ_W-1:0]  next_seq;
   logic [CNT_W-1:0]  pairs_left;
   int                errors;
   int                byte_index;
   int                opened;
   int                dropped;
   int                abandoned;

   initial begin
      next_seq       = '0;
      pairs_left     = '0;
      errors         = 0;
      byte_index     = 0;
      opened         = 0;
      dropped        = 0;
      abandoned      = 0;
      mismatch_count = 0;
      pending_bytes  = 0;
      bytes_checked  = 0;
      packets_opened = 0;
      samples_dropped   = 0;
      packets_abandoned = 0;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 30) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // Offset binary: round-half-up of (s/32768 + 1) * 32767, exact in integers
   function automatic logic [SAMPLE_W-1:0] q15_to_offset(input logic [SAMPLE_W-1:0] s);
      logic [31:0] biased;
      logic [31:0] scaled;
      biased = {16'd0, ~s[SAMPLE_W-1], s[SAMPLE_W-2:0]};
      scaled = biased * 32'd32767 + 32'd16384;
      return scaled[30:15];
   endfunction

   // Step by two; past the top, restart at 1 from an even value and 0 from an odd one
   function automatic logic [SEQ_W-1:0] advance_sequence(input logic [SEQ_W-1:0] s);
      logic [SEQ_W:0] sum;
      sum = {1'b0, s} + 17'd2;
      if (sum[SEQ_W]) begin
         return {{(SEQ_W-1){1'b0}}, ~s[0]};
      end
      return sum[SEQ_W-1:0];
   endfunction

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last, input logic eop);
      framed_byte_type fb;
      fb.data          = b;
      fb.last_of_item  = last;
      fb.end_of_packet = eop;
      expected_bytes.push_back(fb);
   endtask

   task automatic predict_framed_bytes(input logic [SAMPLE_W-1:0] si,
                                       input logic [SAMPLE_W-1:0] sq,
                                       input logic                opens,
                                       input logic [CNT_W-1:0]    cnt_field);
      logic [CNT_W-1:0]    cnt;
      logic [SAMPLE_W-1:0] iv;
      logic [SAMPLE_W-1:0] qv;
      if (opens) begin
         cnt = cnt_field;
         if (cnt == 0) begin
            cnt = 1;
         end
         if (cnt > PACKET_PAIRS_MAX) begin
            cnt = CNT_W'(PACKET_PAIRS_MAX);
         end
         if (pairs_left != 0) begin
            abandoned++;
         end
         opened++;
         push_byte(SYNC_0, 1'b0, 1'b0);
         push_byte(SYNC_1, 1'b0, 1'b0);
         push_byte(next_seq[7:0], 1'b0, 1'b0);
         push_byte(next_seq[15:8], 1'b0, 1'b0);
         push_byte(cnt[7:0], 1'b0, 1'b0);
         push_byte({5'd0, cnt[10:8]}, 1'b0, 1'b0);
         next_seq   = advance_sequence(next_seq);
         pairs_left = cnt;
      end
      // drop a sample that has no open packet to go into
      if (pairs_left == 0) begin
         dropped++;
         return;
      end
      iv = q15_to_offset(si);
      qv = q15_to_offset(sq);
      pairs_left = pairs_left - 1'b1;
      push_byte(iv[15:8], 1'b0, 1'b0);
      push_byte(iv[7:0], 1'b0, 1'b0);
      push_byte(qv[15:8], 1'b0, 1'b0);
      push_byte(qv[7:0], 1'b1, pairs_left == 0);
   endtask

   task automatic check_byte();
      framed_byte_type want;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("byte %02h with nothing expected", rsp_mon.data_byte));
         return;
      end
      want = expected_bytes.pop_front();
      if (rsp_mon.data_byte !== want.data) begin
         report_mismatch($sformatf("byte %0d data_byte want %02h got %02h",
                                   byte_index, want.data, rsp_mon.data_byte));
      end
      if (rsp_mon.last_of_item !== want.last_of_item) begin
         report_mismatch($sformatf("byte %0d last_of_item want %0b got %0b",
                                   byte_index, want.last_of_item, rsp_mon.last_of_item));
      end
      if (rsp_mon.end_of_packet !== want.end_of_packet) begin
         report_mismatch($sformatf("byte %0d end_of_packet want %0b got %0b",
                                   byte_index, want.end_of_packet, rsp_mon.end_of_packet));
      end
      byte_index++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            predict_framed_bytes(req_mon.sample_i, req_mon.sample_q,
                                 req_mon.first_of_packet, req_mon.packet_samples);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_byte();
         end
      end
      mismatch_count    <= errors;
      pending_bytes     <= expected_bytes.size();
      bytes_checked     <= byte_index;
      packets_opened    <= opened;
      samples_dropped   <= dropped;
      packets_abandoned <= abandoned;
   end

endmodule

// ----- verif/tb_iq_sample_packet_framer.sv -----
`timescale 1ns / 1ps
// Top of the I/Q packet framer testbench: clock, reset, stimulus, receiver and verdict.
// Depends on iqf_pkg, iqf_if, the framer RTL and iq_framer_byte_checker.
module tb_iq_sample_packet_framer;
   import iqf_pkg::*;

   localparam int RANDOM_ITEMS  = 130;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int IDLE_PERCENT  = 36;

   logic clock;
   logic reset;

   iqf_req_if req_ch();
   iqf_rsp_if rsp_ch();

   int mismatch_count;
   int pending_bytes;
   int bytes_checked;
   int packets_opened;
   int samples_dropped;
   int packets_abandoned;

   // steady and hold_request are shared between sender and receiver; the rest is local process state
   logic steady;
   logic hold_request;
   logic hold_done;
   int   hold_left;
   int   items_sent;
   int   quiet_cycles;

   // Stimulus scratch
   int kind;
   int n;
   int k;
   int base;

   iq_sample_packet_framer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   iq_framer_byte_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_ch),
      .rsp_mon           (rsp_ch),
      .mismatch_count    (mismatch_count),
      .pending_bytes     (pending_bytes),
      .bytes_checked     (bytes_checked),
      .packets_opened    (packets_opened),
      .samples_dropped   (samples_dropped),
      .packets_abandoned (packets_abandoned)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Mostly random values, with the field extremes and zero/minus one mixed in
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one sample transaction and hold it until the block takes it.
   // Called at a rising edge; returns at the edge that accepted it.
   task automatic send_pair(input logic [SAMPLE_W-1:0] si, input logic [SAMPLE_W-1:0] sq,
                            input logic opens, input logic [CNT_W-1:0] cnt);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.sample_i        <= si;
      req_ch.sample_q        <= sq;
      req_ch.first_of_packet <= opens;
      req_ch.packet_samples  <= cnt;
      do begin
         @(posedge clock);
      end while (!(req_ch.valid && req_ch.ready));
      items_sent++;
   endtask

   // Receiver: random stalls, a stall-free stretch, and one long hold-off
   // that lets the job queue fill so the input side has to stall too.
   initial begin
      rsp_ch.ready <= 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end else if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a transaction
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d bytes outstanding",
                  quiet_cycles, pending_bytes);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.sample_i        <= '0;
      req_ch.sample_q        <= '0;
      req_ch.first_of_packet <= 1'b0;
      req_ch.packet_samples  <= '0;
      steady       = 1'b0;
      hold_request = 1'b0;
      items_sent   = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      // Stray sample right after reset: no packet is open, so drop it.
      send_pair(16'h8000, 16'h7FFF, 1'b0, 11'd0);
      // Count zero goes out as one pair; most negative I, most positive Q.
      send_pair(16'h8000, 16'h7FFF, 1'b1, 11'd0);
      // Packet closed again: drop this one, its count field is ignored.
      send_pair(16'h7FFF, 16'h8000, 1'b0, 11'h7FF);
      // All-ones count saturates at the maximum; leave the packet open.
      send_pair(16'h0000, 16'hFFFF, 1'b1, 11'h7FF);
      send_pair(16'h0001, 16'hFFFE, 1'b0, 11'd0);
      // New start while open: abandon the old packet without an end mark.
      send_pair(16'hFFFF, 16'h0000, 1'b1, 11'd3);
      send_pair(16'h4000, 16'hC000, 1'b0, 11'd0);
      send_pair(16'h8001, 16'h7FFE, 1'b0, 11'd0);
      // Exactly the maximum, then one above it, both abandoned.
      send_pair(16'h3039, 16'hCFC7, 1'b1, 11'd1024);
      send_pair(16'hFFFF, 16'hFFFF, 1'b1, 11'd1025);
      send_pair(16'h0000, 16'h0000, 1'b1, 11'd1);
      // Alternating bit patterns in samples and count fields
      send_pair(16'h5555, 16'hAAAA, 1'b1, 11'd2);
      send_pair(16'hAAAA, 16'h5555, 1'b0, 11'h555);
      send_pair(16'h7FFF, 16'h7FFF, 1'b1, 11'h2AA);
      send_pair(16'h8000, 16'h8000, 1'b1, 11'd1023);
      send_pair(16'h0002, 16'hFFFD, 1'b1, 11'd2);
      send_pair(16'h00FF, 16'hFF00, 1'b0, 11'd0);
      send_pair(16'h0064, 16'hFF9C, 1'b0, 11'd5);

      // Random part: mostly well-formed packets with random content, the rest
      // broken packets (random count, cut short) and stray samples.
      @(posedge clock);
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         // one hold-off early, one stall-free stretch in the middle
         if (items_sent - base >= 30) begin
            hold_request = 1'b1;
         end
         steady = (items_sent - base >= 70) && (items_sent - base < 110);
         kind = $urandom_range(99);
         if (kind < 70 || kind >= 90) begin
            n = (kind < 70) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            send_pair(pick_sample(), pick_sample(), 1'b1,
                      (n == 1 && $urandom_range(3) == 0) ? 11'd0 : CNT_W'(n));
            for (k = 1; k < n; k++) begin
               send_pair(pick_sample(), pick_sample(), 1'b0, CNT_W'($urandom));
            end
         end else if (kind < 80) begin
            send_pair(pick_sample(), pick_sample(), 1'b1, CNT_W'($urandom_range(0, 2047)));
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++) begin
               send_pair(pick_sample(), pick_sample(), 1'b0, CNT_W'($urandom));
            end
         end else begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
               send_pair(pick_sample(), pick_sample(), 1'b0, CNT_W'($urandom));
            end
         end
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      // Wait out every predicted byte; the watchdog bounds this.
      @(posedge clock);
      while (pending_bytes != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      $display("run covered %0d sample transactions: %0d packets opened, %0d abandoned,",
               items_sent, packets_opened, packets_abandoned);
      $display("%0d samples dropped outside a packet, %0d bytes checked, %0d mismatches",
               samples_dropped, bytes_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
